>>> rtl/core/plane_set_clip_test_core_macros.svh
// assertion macros for the plane set clip test core
`ifndef PLANE_SET_CLIP_TEST_CORE_MACROS_SVH
`define PLANE_SET_CLIP_TEST_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define PSCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define PSCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/psct_pkg.sv
// shared types and constants for the plane set clip test core
package psct_pkg;
   localparam int MaxPlanes = 8;
   localparam int IdxW = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;
   localparam int CntW = $clog2(MaxPlanes + 1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_POINT = 2'd2,
      OP_BOX   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_IN    = 2'd0,
      VERDICT_OUT   = 2'd1,
      VERDICT_INTER = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_NEXT,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic add;
      logic mul;
      logic sum;
      logic judge;
      logic [IdxW-1:0] idx;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic [CntW-1:0] count;
      logic resolved;
   } stat_type;
endpackage

>>> rtl/core/psct_datapath.sv
// plane store, corner distance units and verdict accumulation
module psct_datapath import psct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic [1:0]   in_op,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   input  logic signed [31:0] in_d,
   input  logic signed [31:0] in_mx,
   input  logic signed [31:0] in_my,
   input  logic signed [31:0] in_mz,
   input  logic         in_bv,
   output logic [1:0]   verdict,
   output logic         status
);
   logic signed [31:0] nx_mem [MaxPlanes];
   logic signed [31:0] ny_mem [MaxPlanes];
   logic signed [31:0] nz_mem [MaxPlanes];
   logic signed [31:0] d_mem  [MaxPlanes];
   logic [CntW-1:0] count_ff, count_in;
   logic [1:0] op_ff;
   logic bv_ff;
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];
   logic signed [63:0] px_ff [8];
   logic signed [63:0] py_ff [8];
   logic signed [63:0] pz_ff [8];
   logic signed [63:0] pd_ff;
   logic [7:0] neg_ff;
   logic [1:0] verdict_ff, verdict_in;
   logic status_ff, done_ff, done_in;
   logic full;

   assign full = (count_ff == CntW'(MaxPlanes));

   // plane table writes
   always_ff @(posedge clock) begin
      if (cmd.add && !full) begin
         nx_mem[count_ff[IdxW-1:0]] <= in_x;
         ny_mem[count_ff[IdxW-1:0]] <= in_y;
         nz_mem[count_ff[IdxW-1:0]] <= in_z;
         d_mem[count_ff[IdxW-1:0]]  <= in_d;
      end
   end

   // plane count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.add && !full) count_in = count_ff + CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   // item capture, products and corner sums
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         bv_ff <= in_bv;
         lo_ff[0] <= in_x; lo_ff[1] <= in_y; lo_ff[2] <= in_z;
         hi_ff[0] <= in_mx; hi_ff[1] <= in_my; hi_ff[2] <= in_mz;
      end
      if (cmd.mul) begin
         for (int c = 0; c < 8; c++) begin
            px_ff[c] <= nx_mem[cmd.idx] * (c[0] ? hi_ff[0] : lo_ff[0]);
            py_ff[c] <= ny_mem[cmd.idx] * (c[1] ? hi_ff[1] : lo_ff[1]);
            pz_ff[c] <= nz_mem[cmd.idx] * (c[2] ? hi_ff[2] : lo_ff[2]);
         end
         pd_ff <= {{16{d_mem[cmd.idx][31]}}, d_mem[cmd.idx], 16'd0};
      end
      if (cmd.sum) begin
         for (int c = 0; c < 8; c++) begin
            neg_ff[c] <= ($signed({{2{px_ff[c][63]}}, px_ff[c]})
                        + $signed({{2{py_ff[c][63]}}, py_ff[c]})
                        + $signed({{2{pz_ff[c][63]}}, pz_ff[c]})
                        + $signed({{2{pd_ff[63]}}, pd_ff})) < 0;
         end
      end
   end

   // verdict accumulation per plane
   always_comb begin
      verdict_in = verdict_ff;
      done_in = done_ff;
      if (cmd.load) begin
         verdict_in = (in_op == OP_BOX && !in_bv) ? VERDICT_INTER : VERDICT_IN;
         done_in = (in_op == OP_BOX && !in_bv);
      end else if (cmd.judge && !done_ff) begin
         if (op_ff == OP_POINT) begin
            if (neg_ff[0]) begin
               verdict_in = VERDICT_OUT;
               done_in = 1'b1;
            end
         end else if (&neg_ff) begin
            verdict_in = VERDICT_OUT;
            done_in = 1'b1;
         end else if (|neg_ff) begin
            verdict_in = VERDICT_INTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_ff <= VERDICT_IN;
         done_ff <= 1'b0;
         status_ff <= 1'b0;
      end else begin
         verdict_ff <= verdict_in;
         done_ff <= done_in;
         // an add into a full table is flagged, every other item clears it
         if (cmd.load) status_ff <= cmd.add && full;
      end
   end

   assign stat.full = full;
   assign stat.count = count_ff;
   assign stat.resolved = done_ff;
   assign verdict = verdict_ff;
   assign status = status_ff;
endmodule

>>> rtl/core/psct_ctrl.sv
// sequencer over the stored planes
module psct_ctrl import psct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  stat_type   stat
);
   state_type state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic last;

   assign last = ({1'b0, idx_ff} == stat.count - CntW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.idx = idx_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in = '0;
               cmd.clear = (req_op == OP_CLEAR);
               cmd.add = (req_op == OP_ADD);
               if (req_op inside {OP_POINT, OP_BOX} && stat.count != '0)
                  state_in = ST_MUL;
               else
                  state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.judge = 1'b1;
            if (last) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IdxW'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> rtl/core/plane_set_clip_test_core.sv
// Plane set clip test core: clears, appends to (up to 8 planes) or tests a point or an
// axis-aligned box against a table of Q16.16 clip planes, one result per item. The result
// of a clear or an add is offered in the cycle after the item is taken. A point or box
// test with a non-empty table first walks every stored plane one at a time, each through
// a multiply stage (24 products for the eight corners at once), an exact sum stage and a
// judge stage, even when an invalid box or an early outside verdict has already settled
// the answer; with an empty table its result is offered like that of a clear. A result
// stall holds the result and delays the next item. One item is in flight at a time;
// the next is taken once the result transfer is done.
module plane_set_clip_test_core import psct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_coef_x,
   input  logic signed [31:0] req_coef_y,
   input  logic signed [31:0] req_coef_z,
   input  logic signed [31:0] req_plane_offset,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic               req_box_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_verdict,
   output logic               rsp_status
);
   cmd_type  cmd;
   stat_type stat;

   psct_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_op,
      .rsp_valid, .rsp_stall, .cmd, .stat
   );

   psct_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .in_op(req_op), .in_x(req_coef_x), .in_y(req_coef_y), .in_z(req_coef_z),
      .in_d(req_plane_offset), .in_mx(req_box_max_x), .in_my(req_box_max_y),
      .in_mz(req_box_max_z), .in_bv(req_box_valid),
      .verdict(rsp_verdict), .status(rsp_status)
   );
endmodule

>>> rtl/core/psct_checker.sv
// port-level checks for the plane set clip test core
`include "plane_set_clip_test_core_macros.svh"
module psct_checker import psct_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_verdict,
   input logic       rsp_status
);
   `PSCT_ASSERT_IMP(a_verdict_code, clock, reset, rsp_valid, rsp_verdict <= VERDICT_INTER)
   `PSCT_ASSERT_IMP(a_status_excl, clock, reset, rsp_valid && rsp_status, rsp_verdict == VERDICT_IN)
   `PSCT_ASSERT_IMP(a_busy_when_rsp, clock, reset, rsp_valid, req_stall)
   `PSCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_verdict))
endmodule

bind plane_set_clip_test_core psct_checker u_psct_checker (.*);
